/* rtl/ias_pkg.sv */
// shared types and the ordering compare for the integer array sorter
// used by ias_cell and integer_array_sorter, no dependencies
package ias_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic insert;
    logic shift_out;
    logic descending;
  } ias_ctrl_t;

  // true when a strictly precedes b in the selected order
  function automatic logic goes_before(input value_t a, input value_t b,
                                       input logic descending);
    logic res;
    if (descending) begin
      res = (a > b);
    end else begin
      res = (a < b);
    end
    return res;
  endfunction

endpackage

/* rtl/ias_cell.sv */
// one cell of the insertion sort chain: holds one value and its valid bit
// depends on ias_pkg
module ias_cell
  import ias_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ias_ctrl_t ctrl,
  input  value_t    new_value,
  input  value_t    left_value,
  input  logic      left_valid,
  input  logic      left_grant,
  input  value_t    right_value,
  input  logic      right_valid,
  output value_t    value,
  output logic      valid,
  output logic      grant
);

  value_t value_r;
  value_t value_nxt;
  logic   valid_r;
  logic   valid_nxt;
  logic   take;

  assign take  = !valid_r || goes_before(new_value, value_r, ctrl.descending);
  assign grant = ctrl.insert && take && (valid_r || left_valid);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.shift_out) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end else if (grant) begin
      value_nxt = left_grant ? left_value : new_value;
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule

/* rtl/integer_array_sorter.sv */
// integer array sorter top level: a chain of ias_cell instances kept in order
// depends on ias_pkg and ias_cell
//
// usage:
//  - in_* channel: one signed 32-bit value per transfer, in_tlast marks the
//    final value of a set; one value is taken every cycle while collecting
//  - each value is placed in order on arrival, all cells compare in parallel
//    against the new value and the displaced values move one cell right
//  - on the marked transfer the chain drains from cell 0, one result per
//    cycle on out_* while out_tready is high, out_tlast on a set's last result
//  - out_tuser is set on every result of a set that lost values because the
//    chain already held MAX_ITEMS values; those values are dropped
//  - the marked transfer sets the drain flag and each result is registered
//    before out_*; in_tready is low for the drain
//  - a stall on out_tready holds the output register and halts the drain
//  - cfg_* writes the order bit (0 ascending, 1 descending signed); write it
//    only while the chain is empty, neither collecting nor draining a set
//  - reset (rst_n low, synchronous) empties the chain and selects ascending
module integer_array_sorter
  import ias_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast,
  output logic        out_tuser,  // [0] overflow
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          drop_r;
  logic          drop_nxt;
  logic          drain_r;
  logic          drain_nxt;
  logic          desc_r;
  logic          in_xfer;
  logic          full;
  logic          drain_step;
  logic          out_valid_r;
  value_t        out_data_r;
  logic          out_last_r;
  logic          out_user_r;

  ias_ctrl_t ctrl;
  value_t    cell_value [MAX_ITEMS];
  logic      cell_valid [MAX_ITEMS];
  logic      cell_grant [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] valid_vec;

  assign in_tready  = !drain_r;
  assign cfg_ready  = 1'b1;
  assign in_xfer    = in_tvalid && in_tready;
  assign full       = (count_r == CW'(MAX_ITEMS));
  assign drain_step = drain_r && (!out_valid_r || out_tready);

  assign ctrl.insert     = in_xfer && !full;
  assign ctrl.shift_out  = drain_step;
  assign ctrl.descending = desc_r;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
      value_t lv;
      logic   lval;
      logic   lgnt;
      value_t rv;
      logic   rval;
      if (gi == 0) begin : g_first
        assign lv   = '0;
        assign lval = 1'b1;
        assign lgnt = 1'b0;
      end else begin : g_mid
        assign lv   = cell_value[gi-1];
        assign lval = cell_valid[gi-1];
        assign lgnt = cell_grant[gi-1];
      end
      if (gi == MAX_ITEMS - 1) begin : g_end
        assign rv   = '0;
        assign rval = 1'b0;
      end else begin : g_nend
        assign rv   = cell_value[gi+1];
        assign rval = cell_valid[gi+1];
      end
      ias_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .new_value   (value_t'(in_tdata)),
        .left_value  (lv),
        .left_valid  (lval),
        .left_grant  (lgnt),
        .right_value (rv),
        .right_valid (rval),
        .value       (cell_value[gi]),
        .valid       (cell_valid[gi]),
        .grant       (cell_grant[gi])
      );
      assign valid_vec[gi] = cell_valid[gi];
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    drain_nxt = drain_r;
    if (in_xfer) begin
      if (!full) begin
        count_nxt = count_r + CW'(1);
      end else begin
        drop_nxt = 1'b1;
      end
      if (in_tlast) begin
        drain_nxt = 1'b1;
      end
    end else if (drain_step) begin
      count_nxt = count_r - CW'(1);
      if (count_r == CW'(1)) begin
        drain_nxt = 1'b0;
        drop_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      drop_r      <= 1'b0;
      drain_r     <= 1'b0;
      desc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
      drain_r <= drain_nxt;
      if (cfg_valid && cfg_ready) begin
        desc_r <= cfg_data;
      end
      if (drain_step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (drain_step) begin
      out_data_r <= cell_value[0];
      out_last_r <= (count_r == CW'(1));
      out_user_r <= drop_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    CW'($countones(valid_vec)) == count_r)
    else $error("stored count differs from occupied cells");

  a_drain_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> (count_r != '0))
    else $error("draining with an empty chain");

  a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (drain_step && count_r == CW'(1)) |=> (!drain_r && count_r == '0 && !drop_r))
    else $error("drain did not finish after the final result");

  a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (drop_r && !drain_r) |-> full)
    else $error("drop flag set while chain not full");

endmodule

/* sim/integer_array_sorter_checker.sv */
// checker for integer_array_sorter: watches the input, result and order channels,
// predicts each sorted set and compares every result transfer against it
// depends on ias_pkg
`timescale 1ns / 1ps

module integer_array_sorter_checker
  import ias_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  output int unsigned error_count,
  output int unsigned pending_results,
  output int unsigned results_checked
);

  typedef struct {
    value_t value;
    logic   last;
    logic   overflow;
  } sorted_result_t;

  value_t         held_values[$];
  sorted_result_t sorted_results[$];
  logic           values_dropped;
  logic           descending;

  initial begin
    error_count = 0;
    pending_results = 0;
    results_checked = 0;
    values_dropped = 1'b0;
    descending = 1'b0;
  end

  // insertion sort of the held set, then queue one result per held value
  task automatic release_sorted_set();
    value_t         ordered[$];
    sorted_result_t res;
    int             pos;
    foreach (held_values[i]) begin
      pos = 0;
      while (pos < ordered.size() &&
             (descending ? ordered[pos] >= held_values[i] : ordered[pos] <= held_values[i]))
        pos++;
      ordered.insert(pos, held_values[i]);
    end
    foreach (ordered[k]) begin
      res.value = ordered[k];
      res.last = (k == ordered.size() - 1);
      res.overflow = values_dropped;
      sorted_results.push_back(res);
    end
    held_values.delete();
    values_dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    sorted_result_t want;
    if (!rst_n) begin
      held_values.delete();
      sorted_results.delete();
      values_dropped = 1'b0;
      descending = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (sorted_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got value %0d last %0b overflow %0b",
                   $time, $signed(out_tdata), out_tlast, out_tuser);
          error_count++;
        end else begin
          want = sorted_results.pop_front();
          results_checked++;
          if (out_tdata !== want.value || out_tlast !== want.last ||
              out_tuser !== want.overflow) begin
            $display("%0t: result mismatch: expected value %0d last %0b overflow %0b, got value %0d last %0b overflow %0b",
                     $time, want.value, want.last, want.overflow,
                     $signed(out_tdata), out_tlast, out_tuser);
            error_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready)
        descending = cfg_data;
      if (in_tvalid && in_tready) begin
        if (held_values.size() < MAX_ITEMS)
          held_values.push_back(value_t'(in_tdata));
        else
          values_dropped = 1'b1;
        if (in_tlast)
          release_sorted_set();
      end
    end
    pending_results = sorted_results.size();
  end

endmodule

/* sim/tb_integer_array_sorter.sv */
// top of the integer_array_sorter testbench: clock, reset, sets of values with
// random gaps and result stalls, order writes between phases, and the verdict
// depends on ias_pkg, integer_array_sorter and integer_array_sorter_checker
`timescale 1ns / 1ps

module tb_integer_array_sorter;
  import ias_pkg::*;

  localparam int unsigned CAPACITY      = 64;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PHASE_VALUES  = 85;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] value
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] sorted_value
  logic        out_tlast;
  logic        out_tuser;  // [0] overflow
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  int unsigned error_count;
  int unsigned pending_results;
  int unsigned results_checked;

  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned values_sent;
  int unsigned sets_sent;
  int unsigned sets_over_capacity;
  int unsigned quiet_cycles;

  integer_array_sorter #(
    .MAX_ITEMS(CAPACITY)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  integer_array_sorter_checker #(
    .MAX_ITEMS(CAPACITY)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .error_count    (error_count),
    .pending_results(pending_results),
    .results_checked(results_checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // no transfer on any channel for too long means the block is stuck
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_value(input logic [31:0] value, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    @(posedge clk);
    while (!(in_tvalid && in_tready)) @(posedge clk);
    @(negedge clk);
    values_sent++;
    if (last)
      sets_sent++;
  endtask

  task automatic write_order(input logic descending);
    cfg_valid <= 1'b1;
    cfg_data  <= descending;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(9))
      0:       v = 32'h7fff_ffff;
      1:       v = 32'h8000_0000;
      2, 3:    v = 32'($urandom_range(8)) - 32'd4;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_random_set();
    int unsigned count;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70)
      count = $urandom_range(8, 1);
    else if (pick < 85)
      count = $urandom_range(40, 9);
    else begin
      case ($urandom_range(4))
        0:       count = CAPACITY - 1;
        1:       count = CAPACITY;
        2:       count = CAPACITY + 1;
        3:       count = CAPACITY + 2;
        default: count = CAPACITY + 6;
      endcase
    end
    if (count > CAPACITY)
      sets_over_capacity++;
    for (int unsigned i = 0; i < count; i++)
      send_value(pick_value(), i == count - 1);
  endtask

  initial begin
    int unsigned phase_start;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    quiet_cycles = 0;
    values_sent = 0;
    sets_sent = 0;
    sets_over_capacity = 0;
    sender_idle_pct = 23;
    receiver_idle_pct = 80;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_order(1'b0);

    // single value set
    send_value(32'h0000_0000, 1'b1);
    // extremes of the signed range
    send_value(32'h7fff_ffff, 1'b0);
    send_value(32'h8000_0000, 1'b0);
    send_value(32'h0000_0000, 1'b0);
    send_value(32'hffff_ffff, 1'b0);
    send_value(32'h0000_0001, 1'b0);
    send_value(32'h8000_0001, 1'b0);
    send_value(32'h7fff_fffe, 1'b1);
    // equal values
    send_value(32'd5, 1'b0);
    send_value(32'd5, 1'b0);
    send_value(-32'sd5, 1'b0);
    send_value(32'd5, 1'b1);
    // two values already in order, then reversed
    send_value(32'h8000_0000, 1'b0);
    send_value(32'hffff_ffff, 1'b1);
    send_value(32'h7fff_ffff, 1'b0);
    send_value(32'h8000_0000, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 1) begin
        sender_idle_pct = 80;
        receiver_idle_pct = 23;
      end else if (phase >= 2) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      wait_for_drain();
      write_order(phase[0]);
      phase_start = values_sent;
      while (values_sent - phase_start < PHASE_VALUES)
        send_random_set();
    end

    wait_for_drain();
    $display("sent %0d values in %0d sets (%0d over capacity), checked %0d sorted results",
             values_sent, sets_sent, sets_over_capacity, results_checked);
    $display("both sort orders, sender and receiver stalls in turn and back-to-back transfers");
    if (error_count == 0 && pending_results == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

/* sim.f */
rtl/ias_pkg.sv
rtl/ias_cell.sv
rtl/integer_array_sorter.sv
sim/integer_array_sorter_checker.sv
sim/tb_integer_array_sorter.sv
